>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the palette quantizer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpq: implication failed");

// Implication whose consequent is checked in the next cycle.
`define RPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpq: next-cycle implication failed");

`endif

>>> hw/rtl/rpq_pkg.sv
// Package for the RGBA palette quantizer: sequencer states, codes and constants.
// No dependencies; used by the quantizer, both checkers and the bench top.
package rpq_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam int CHAN_W  = 8;
  localparam int ENTRY_W = 3 * CHAN_W;
  localparam int DIST_W  = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 1'b1;

  localparam logic [CHAN_W-1:0] TRANSP_RESET = 8'd4;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Largest squared RGB distance, 3 * 255 * 255
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  // Luma weights with 16 fractional bits
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN
  } state_e;

endpackage

>>> hw/rtl/rpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rgba_palette_quantizer.sv
// Palette write: no result, and in_ready stays high for the next item. Transparent or
// grayscale pixel: the result passes EVAL, the pending and then the output register;
// no new item is taken before it leaves the pending register. Palette pixel: EVAL, a
// scan of all entries at one palette RAM read per cycle, DRAIN, then the same hand-off.
// Reset: control and config registers clear at once (palette mode off, transparent 4);
// the palette RAM has no clearing pass and holds garbage until written.
module rgba_palette_quantizer
  import rpq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            entry_index_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            alpha_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            color_index_o
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LastIdx = AW'(PALETTE_ENTRIES - 1);

  state_e state_q, state_d;

  logic              use_pal_q;
  logic [7:0]        transp_q;
  logic [7:0]        px_r_q, px_g_q, px_b_q, px_a_q;
  logic              in_acc;
  logic              pal_we;

  logic [AW-1:0]     rd_addr_q;
  logic              rd_en;
  logic              rd_v_q, rd_last_q;
  logic [AW-1:0]     rd_idx_q;
  logic [ENTRY_W-1:0] rd_data;

  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] dist_q;
  logic              dist_v_q, dist_last_q;
  logic [AW-1:0]     dist_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [AW-1:0]     best_idx_q;
  logic              closer;
  logic              scan_init;

  logic [23:0]       luma;
  logic              pend_load;
  logic [7:0]        pend_val;
  logic              pend_v_q;
  logic [7:0]        pend_q;
  logic              out_v_q;
  logic [7:0]        out_q;
  logic              out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign pal_we   = in_acc && (opcode_i == OP_WRITE)
                    && ({1'b0, entry_index_i} < 9'(PALETTE_ENTRIES));
  assign out_free = !out_v_q || out_ready_i;

  // Writes happen only in IDLE and scan reads only in SCAN, so no
  // read and write of the same entry can overlap.
  rpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // Config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_pal_q <= 1'b0;
      transp_q  <= TRANSP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAL_MODE:    use_pal_q <= cfg_data_i[0];
        CFG_TRANSPARENT: transp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (opcode_i == OP_PIXEL)) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if ((px_a_q == ALPHA_OPAQUE) && use_pal_q) state_d = ST_SCAN;
        else state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_addr_q == LastIdx) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (dist_v_q && dist_last_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign luma = 24'(LUMA_R) * 24'(px_r_q) + 24'(LUMA_G) * 24'(px_g_q)
              + 24'(LUMA_B) * 24'(px_b_q);
  assign closer = dist_q < best_dist_q;

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    scan_init  = 1'b0;
    pend_load  = 1'b0;
    pend_val   = transp_q;
    unique case (state_q)
      ST_IDLE: in_ready_o = !pend_v_q;
      ST_EVAL: begin
        scan_init = 1'b1;
        if (px_a_q != ALPHA_OPAQUE) begin
          pend_load = 1'b1;
          pend_val  = transp_q;
        end else if (!use_pal_q) begin
          pend_load = 1'b1;
          pend_val  = luma[23:16];
        end
      end
      ST_SCAN: rd_en = 1'b1;
      ST_DRAIN: begin
        if (dist_v_q && dist_last_q) begin
          pend_load = 1'b1;
          pend_val  = closer ? 8'(dist_idx_q) : 8'(best_idx_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pixel held for the duration of the item
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == OP_PIXEL)) begin
      px_r_q <= red_i;
      px_g_q <= green_i;
      px_b_q <= blue_i;
      px_a_q <= alpha_i;
    end
  end

  // Squared distance of the entry just read
  always_comb begin
    logic [7:0] dr, dg, db;
    dr = (px_r_q > rd_data[23:16]) ? px_r_q - rd_data[23:16] : rd_data[23:16] - px_r_q;
    dg = (px_g_q > rd_data[15:8])  ? px_g_q - rd_data[15:8]  : rd_data[15:8]  - px_g_q;
    db = (px_b_q > rd_data[7:0])   ? px_b_q - rd_data[7:0]   : rd_data[7:0]   - px_b_q;
    cand_dist = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg)
              + DIST_W'(db) * DIST_W'(db);
  end

  // Scan pipeline: address, RAM data, distance, compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      dist_v_q    <= 1'b0;
      dist_last_q <= 1'b0;
    end else begin
      rd_v_q      <= rd_en;
      rd_last_q   <= rd_en && (rd_addr_q == LastIdx);
      dist_v_q    <= rd_v_q;
      dist_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_init) begin
      rd_addr_q <= '0;
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end
    rd_idx_q   <= rd_addr_q;
    dist_q     <= cand_dist;
    dist_idx_q <= rd_idx_q;
    // strict compare keeps the lowest-numbered entry on ties
    if (scan_init) begin
      best_dist_q <= MAX_DIST;
      best_idx_q  <= '0;
    end else if (dist_v_q && closer) begin
      best_dist_q <= dist_q;
      best_idx_q  <= dist_idx_q;
    end
  end

  // Pending result and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (pend_load) begin
        pend_v_q <= 1'b1;
      end else if (pend_v_q && out_free) begin
        pend_v_q <= 1'b0;
      end
      if (pend_v_q && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_q <= pend_val;
    end
    if (pend_v_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign color_index_o = out_q;

endmodule

>>> hw/rtl/rpq_checker.sv
// Port-level checker for the palette quantizer, bound to the top level.
// Depends on rpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpq_checker
  import rpq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  opcode_i,
  input logic [7:0]            entry_index_i,
  input logic [7:0]            red_i,
  input logic [7:0]            green_i,
  input logic [7:0]            blue_i,
  input logic [7:0]            alpha_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [7:0]            color_index_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a stalled result holds its value
  `RPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(color_index_o))

  // a pixel keeps the block busy for at least the next cycle
  `RPQ_ASSERT_NEXT(a_pixel_busy, clk_i, rst_ni, in_acc && (opcode_i == OP_PIXEL), !in_ready_o)

  // palette writes never create a result
  `RPQ_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_acc && (opcode_i == OP_WRITE) && !out_valid_o, !out_valid_o)

  // a translucent pixel taken while no result is shown passes EVAL and the pending register to the output
  `RPQ_ASSERT_IMPL(a_transp_latency, clk_i, rst_ni, in_acc && (opcode_i == OP_PIXEL) && (alpha_i != ALPHA_OPAQUE) && !out_valid_o, ##3 out_valid_o)

endmodule

bind rgba_palette_quantizer rpq_checker u_rpq_checker (.*);

>>> bench/quant_checker.sv
`timescale 1ns / 100ps
// Checker for the RGBA palette quantizer: follows config writes and both handshakes,
// predicts each color_index in order and compares. Depends on rpq_pkg.
module quant_checker
  import rpq_pkg::*;
#(
  parameter int ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  opcode_i,
  input  logic [7:0]            entry_index_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            alpha_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            color_index_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    checked_o
);

  logic [ENTRY_W-1:0] palette_q [ENTRIES];
  logic               map_mode_q = 1'b0;
  logic [7:0]         transp_idx_q = TRANSP_RESET;
  logic [7:0]         expected_idx_q [$];
  int                 mismatch_cnt = 0;
  int                 checked_cnt = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic int unsigned sq_delta(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic logic [7:0] predict_index(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a);
    int unsigned best_dist;
    int unsigned cand_dist;
    logic [7:0]  best;
    logic [31:0] luma;
    if (a != ALPHA_OPAQUE) return transp_idx_q;
    if (!map_mode_q) begin
      luma = LUMA_R * r + LUMA_G * g + LUMA_B * b;
      return luma[23:16];
    end
    best      = '0;
    best_dist = MAX_DIST;
    // strict compare keeps the lowest entry on ties
    for (int p = 0; p < ENTRIES; p++) begin
      cand_dist = sq_delta(r, palette_q[p][23:16]) + sq_delta(g, palette_q[p][15:8]) +
                  sq_delta(b, palette_q[p][7:0]);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = 8'(p);
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [7:0] want;
    if (!rst_ni) begin
      map_mode_q    = 1'b0;
      transp_idx_q  = TRANSP_RESET;
      expected_idx_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAL_MODE:    map_mode_q    = cfg_data_i[0];
          CFG_TRANSPARENT: transp_idx_q  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == OP_WRITE) begin
          if (int'(entry_index_i) < ENTRIES) palette_q[entry_index_i] = {red_i, green_i, blue_i};
        end else begin
          expected_idx_q.push_back(predict_index(red_i, green_i, blue_i, alpha_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_idx_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: color_index %0d arrived with nothing expected", $time, color_index_i);
        end else begin
          want = expected_idx_q.pop_front();
          checked_cnt++;
          if (color_index_i !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: color_index mismatch: expected %0d, got %0d", $time, want,
                       color_index_i);
          end
        end
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= expected_idx_q.size();
    checked_o    <= checked_cnt;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the palette quantizer bench: clock, reset, stimulus, output stalls and verdict.
// Depends on rpq_pkg, rgba_palette_quantizer and quant_checker.
module tb_top;
  import rpq_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_WRITE;
  logic [7:0]            entry_index = '0;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic [7:0]            alpha = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            color_index;

  int          mismatches;
  int          pending;
  int          checked;
  int          quiet_cycles = 0;
  int          writes_sent = 0;
  int          reg_writes = 0;
  bit          hold_off_req = 1'b0;
  bit          no_idle = 1'b0;
  logic [23:0] pal_shadow [256];

  always #(CLK_PERIOD / 2) clk = ~clk;

  rgba_palette_quantizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .entry_index_i (entry_index),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .alpha_i       (alpha),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .color_index_o (color_index)
  );

  quant_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .entry_index_i (entry_index),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .alpha_i       (alpha),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .color_index_i (color_index),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Called at a rising edge; returns at a rising edge after the item is taken.
  task automatic send_item(input logic op, input logic [7:0] idx, input logic [23:0] rgb,
                           input logic [7:0] a);
    int gap;
    int roll;
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    red         <= rgb[23:16];
    green       <= rgb[15:8];
    blue        <= rgb[7:0];
    alpha       <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) begin
      pal_shadow[idx] = rgb;
      writes_sent++;
    end
    roll = $urandom_range(99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(3, 1);
    else if (roll < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(80, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every result, then let a write still in flight land.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  initial begin : stimulus
    logic [23:0] rgb;
    logic [7:0]  a;
    logic [7:0]  transp_plan [PHASES];
    int          roll;
    int          val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grayscale mode at reset settings: extremes, primaries and two translucent pixels
    send_item(OP_PIXEL, 8'd0, 24'h000000, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd255, 24'hFFFFFF, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'hFF0000, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'h00FF00, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'h0000FF, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'h808080, 8'd254);
    send_item(OP_PIXEL, 8'd0, 24'hFFFFFF, 8'd0);
    // alpha means nothing on a palette write
    send_item(OP_WRITE, 8'd0, 24'h000000, 8'd0);
    send_item(OP_WRITE, 8'd255, 24'hFFFFFF, 8'd128);
    wait_idle();
    write_reg(CFG_TRANSPARENT, 8'd255);
    send_item(OP_PIXEL, 8'd0, 24'h102030, 8'd1);
    wait_idle();
    write_reg(CFG_TRANSPARENT, 8'd0);
    send_item(OP_PIXEL, 8'd0, 24'h102030, 8'd127);

    // all entries white: a black pixel is at the largest distance from every one
    for (int e = 0; e < 256; e++) send_item(OP_WRITE, 8'(e), 24'hFFFFFF, 8'(e));
    wait_idle();
    write_reg(CFG_PAL_MODE, 8'd1);
    send_item(OP_PIXEL, 8'd0, 24'h000000, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'hFFFFFF, ALPHA_OPAQUE);
    send_item(OP_WRITE, 8'd17, 24'h000000, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'h000000, ALPHA_OPAQUE);
    // equal match at a lower entry must win
    send_item(OP_WRITE, 8'd3, 24'h000000, 8'd0);
    send_item(OP_PIXEL, 8'd0, 24'h000000, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'hA5, 24'h010101, ALPHA_OPAQUE);
    send_item(OP_PIXEL, 8'd0, 24'h000000, 8'd254);

    for (int e = 0; e < 256; e++) send_item(OP_WRITE, 8'(e), 24'($urandom), 8'($urandom));

    transp_plan[0] = 8'd255;
    transp_plan[1] = 8'd0;
    transp_plan[2] = 8'($urandom);
    transp_plan[3] = 8'($urandom);
    transp_plan[4] = TRANSP_RESET;
    transp_plan[5] = 8'($urandom);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_PAL_MODE, (ph % 2 == 0) ? 8'd1 : 8'd0);
      write_reg(CFG_TRANSPARENT, transp_plan[ph]);
      if (ph == 1) begin
        // output held off while gray pixels keep coming: fills the block
        hold_off_req = 1'b1;
        no_idle      = 1'b1;
        repeat (30) send_item(OP_PIXEL, 8'($urandom), 24'($urandom), ALPHA_OPAQUE);
        wait_idle();
      end
      no_idle = (ph == 3);
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          // some writes copy another entry so that ties show up
          rgb = (roll < 6) ? pal_shadow[$urandom_range(255)] : 24'($urandom);
          send_item(OP_WRITE, 8'($urandom), rgb, 8'($urandom));
        end else begin
          rgb = pal_shadow[$urandom_range(255)];
          if (roll < 45) begin
            for (int c = 0; c < 3; c++) begin
              val = int'(rgb[c*8 +: 8]) + int'($urandom_range(6)) - 3;
              if (val < 0) val = 0;
              else if (val > 255) val = 255;
              rgb[c*8 +: 8] = 8'(val);
            end
          end else if (roll >= 55) begin
            rgb = 24'($urandom);
          end
          roll = $urandom_range(99);
          if (roll < 78) a = ALPHA_OPAQUE;
          else if (roll < 84) a = 8'd254;
          else if (roll < 88) a = 8'd0;
          else a = 8'($urandom_range(253));
          send_item(OP_PIXEL, 8'($urandom), rgb, a);
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d pixel results, sent %0d palette writes, %0d register writes",
             checked, writes_sent, reg_writes);
    $display("gray and nearest-entry modes, transparent index extremes, long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int roll;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_left = $urandom_range(30, 1);
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (out_ready) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          hold_left = $urandom_range(30, 1);
        end else begin
          out_ready <= 1'b0;
          if (roll < 85) hold_left = $urandom_range(2, 0);
          else if (roll < 97) hold_left = $urandom_range(15, 4);
          else hold_left = $urandom_range(60, 20);
        end
      end else begin
        out_ready <= 1'b1;
        hold_left = $urandom_range(30, 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet_cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rpq_pkg.sv
hw/rtl/rpq_ram.sv
hw/rtl/rgba_palette_quantizer.sv
hw/rtl/rpq_checker.sv
bench/quant_checker.sv
bench/tb_top.sv
